// File: design/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and the byte-wide CRC-8 step for the position
// frame checker.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // Frame layout: byte positions within a received buffer
  localparam logic [3:0] PosHeader  = 4'd0;
  localparam logic [3:0] PosLatLast = 4'd4;
  localparam logic [3:0] PosLonLast = 4'd8;
  localparam logic [3:0] PosSeqLast = 4'd10;
  localparam logic [3:0] PosBatt    = 4'd11;
  localparam logic [3:0] PosCrc     = 4'd12;
  localparam logic [3:0] FrameBytes = 4'd13;

  localparam logic [7:0] CrcPoly    = 8'h07;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [1:0]         version;
    logic [5:0]         device_id;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [15:0]        sequence_res;
    logic [7:0]         battery;
  } result_t;

  // One byte through CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/position_frame_checker.sv
// ----------------------------------------------------------------------------
// position_frame_checker
// Checks and decodes 13-byte position records received one byte at a time.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle with no bubbles unless a last byte is held in
// the input register. Each byte sits in an input register, then a single
// byte-wide CRC-8 step (poly 0x07) and the field capture update the frame
// state. When the byte flagged as end of buffer is consumed, the result
// lands in the output register, so out_valid rises once the last byte has
// passed the input register and the result has been registered. Status is
// ok, too short (fewer than 13 bytes) or CRC mismatch; the decoded fields
// are zero unless the status is ok. Bytes past the thirteenth are ignored.
// While a result waits under stall, ordinary bytes keep flowing; only a
// further last byte holds in the input register until the result is taken.
// ----------------------------------------------------------------------------
module position_frame_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               end_of_buffer,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [1:0]         version,
  output logic [5:0]         device_id,
  output logic signed [31:0] latitude,
  output logic signed [31:0] longitude,
  output logic [15:0]        sequence_res,
  output logic [7:0]         battery
);
  import pfc_pkg::*;

  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_last;
  logic       drain;
  logic       load_result;
  logic       out_free;
  result_t    result_d;
  result_t    result_q;

  pfc_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .end_of_buffer (end_of_buffer),
    .drain         (drain),
    .item_valid    (item_valid),
    .item_byte     (item_byte),
    .item_last     (item_last)
  );

  pfc_frame_core u_core (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_byte   (item_byte),
    .item_last   (item_last),
    .out_free    (out_free),
    .drain       (drain),
    .load_result (load_result),
    .result      (result_d)
  );

  pfc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (load_result),
    .result_in (result_d),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result_q  (result_q)
  );

  assign status       = result_q.status;
  assign version      = result_q.version;
  assign device_id    = result_q.device_id;
  assign latitude     = result_q.latitude;
  assign longitude    = result_q.longitude;
  assign sequence_res = result_q.sequence_res;
  assign battery      = result_q.battery;

endmodule

// File: design/pfc_in_reg.sv
// ----------------------------------------------------------------------------
// pfc_in_reg
// Input register: holds one received byte and its end flag until the frame
// core consumes it.
// ----------------------------------------------------------------------------
module pfc_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       end_of_buffer,
  input  logic       drain,
  output logic       item_valid,
  output logic [7:0] item_byte,
  output logic       item_last
);

  logic load;

  assign in_stall = item_valid && !drain;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (drain) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_byte <= rx_byte;
      item_last <= end_of_buffer;
    end
  end

endmodule

// File: design/pfc_frame_core.sv
// ----------------------------------------------------------------------------
// pfc_frame_core
// Frame state: byte count, running CRC, field capture and result forming.
// ----------------------------------------------------------------------------
module pfc_frame_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic [7:0]      item_byte,
  input  logic            item_last,
  input  logic            out_free,
  output logic            drain,
  output logic            load_result,
  output pfc_pkg::result_t result
);
  import pfc_pkg::*;

  logic [3:0]  byte_count, byte_count_next;
  logic [7:0]  running_crc, running_crc_next;
  logic        crc_match, crc_match_next;
  logic [7:0]  header_reg, header_reg_next;
  logic [31:0] lat_reg, lat_reg_next;
  logic [31:0] lon_reg, lon_reg_next;
  logic [15:0] seq_reg, seq_reg_next;
  logic [7:0]  batt_reg, batt_reg_next;
  logic        frame_ok;

  // A last byte waits for room in the result register
  assign drain       = item_valid && (!item_last || out_free);
  assign load_result = drain && item_last;

  always_comb begin
    running_crc_next = running_crc;
    crc_match_next   = crc_match;
    header_reg_next  = header_reg;
    lat_reg_next     = lat_reg;
    lon_reg_next     = lon_reg;
    seq_reg_next     = seq_reg;
    batt_reg_next    = batt_reg;
    byte_count_next  = byte_count;

    if (byte_count < PosCrc) begin
      running_crc_next = crc8_step(running_crc, item_byte);
    end

    if (byte_count == PosHeader) begin
      header_reg_next = item_byte;
    end else if (byte_count <= PosLatLast) begin
      lat_reg_next = {item_byte, lat_reg[31:8]};
    end else if (byte_count <= PosLonLast) begin
      lon_reg_next = {item_byte, lon_reg[31:8]};
    end else if (byte_count <= PosSeqLast) begin
      seq_reg_next = {item_byte, seq_reg[15:8]};
    end else if (byte_count == PosBatt) begin
      batt_reg_next = item_byte;
    end else if (byte_count == PosCrc) begin
      crc_match_next = (item_byte == running_crc);
    end

    if (byte_count < FrameBytes) begin
      byte_count_next = byte_count + 4'd1;
    end
  end

  // Result built from the state as it stands after this byte
  always_comb begin
    frame_ok = 1'b0;
    if (byte_count_next < FrameBytes) begin
      result.status = STATUS_SHORT;
    end else if (!crc_match_next) begin
      result.status = STATUS_CRC_ERR;
    end else begin
      result.status = STATUS_OK;
      frame_ok      = 1'b1;
    end
    result.version      = frame_ok ? header_reg_next[7:6] : 2'd0;
    result.device_id    = frame_ok ? header_reg_next[5:0] : 6'd0;
    result.latitude     = frame_ok ? signed'(lat_reg_next) : 32'sd0;
    result.longitude    = frame_ok ? signed'(lon_reg_next) : 32'sd0;
    result.sequence_res = frame_ok ? seq_reg_next : 16'd0;
    result.battery      = frame_ok ? batt_reg_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || load_result) begin
      byte_count  <= '0;
      running_crc <= '0;
      crc_match   <= 1'b0;
      header_reg  <= '0;
      lat_reg     <= '0;
      lon_reg     <= '0;
      seq_reg     <= '0;
      batt_reg    <= '0;
    end else if (drain) begin
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
      crc_match   <= crc_match_next;
      header_reg  <= header_reg_next;
      lat_reg     <= lat_reg_next;
      lon_reg     <= lon_reg_next;
      seq_reg     <= seq_reg_next;
      batt_reg    <= batt_reg_next;
    end
  end

endmodule

// File: design/pfc_out_reg.sv
// ----------------------------------------------------------------------------
// pfc_out_reg
// Result register: holds one decoded frame result until the consumer takes it.
// ----------------------------------------------------------------------------
module pfc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  pfc_pkg::result_t result_in,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output pfc_pkg::result_t result_q
);
  import pfc_pkg::*;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_in;
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for position_frame_checker. Received buffers, mostly
// well-formed 13-byte records with random content plus long, corrupted and
// short buffers, are queued up front and driven one byte per transaction
// with random gaps. Every accepted byte advances an independent frame
// decoder. Each record the block returns is checked field by field against
// the oldest decoded record.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned ByteTarget = 1550;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
    bit          drain;
  } rx_item_t;

  logic               clk;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte       = '0;
  logic               end_of_buffer = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [1:0]         status;
  logic [1:0]         version;
  logic [5:0]         device_id;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic [15:0]        sequence_res;
  logic [7:0]         battery;

  rx_item_t    pending_bytes[$];
  result_t     expected_records[$];
  int unsigned errors        = 0;
  int unsigned buffers_built = 0;
  int unsigned bytes_sent    = 0;
  int unsigned records_seen  = 0;
  int unsigned ok_count      = 0;
  int unsigned short_count   = 0;
  int unsigned crc_err_count = 0;

  // Decoder state
  logic [3:0]  frame_pos = '0;
  logic [7:0]  run_crc   = '0;
  logic        crc_good  = 1'b0;
  logic [7:0]  hdr_byte  = '0;
  logic [31:0] lat_acc   = '0;
  logic [31:0] lon_acc   = '0;
  logic [15:0] seq_acc   = '0;
  logic [7:0]  batt_byte = '0;

  position_frame_checker u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .end_of_buffer (end_of_buffer),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .version       (version),
    .device_id     (device_id),
    .latitude      (latitude),
    .longitude     (longitude),
    .sequence_res  (sequence_res),
    .battery       (battery)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bit-serial CRC-8, MSB first: feed each data bit against the top bit
  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[7] ^ b[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic last, input bit drain,
                          input bit calm);
    rx_item_t it;
    it.data  = b;
    it.last  = last;
    it.gap   = pick_gap(calm);
    it.drain = drain;
    pending_bytes.push_back(it);
  endtask

  // Twelve body bytes, a check byte (CRC xor flip) and extra trailing bytes
  task automatic add_record(input logic [7:0] body [12], input logic [7:0] crc_flip,
                            input int unsigned extra, input bit drain, input bit calm);
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < 12; i++) begin
      crc = crc_update(crc, body[i]);
      add_byte(body[i], 1'b0, drain && (i == 0), calm);
    end
    add_byte(crc ^ crc_flip, extra == 0, 1'b0, calm);
    for (int i = 1; i <= int'(extra); i++) add_byte(rand_byte(), i == int'(extra), 1'b0, calm);
    buffers_built++;
  endtask

  task automatic add_short(input int unsigned len, input bit drain, input bit calm);
    for (int i = 0; i < int'(len); i++) begin
      add_byte(rand_byte(), i == int'(len) - 1, drain && (i == 0), calm);
    end
    buffers_built++;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    result_t rec;
    if (frame_pos < PosCrc) run_crc = crc_update(run_crc, b);
    if (frame_pos == PosHeader) hdr_byte = b;
    else if (frame_pos <= PosLatLast) lat_acc = {b, lat_acc[31:8]};
    else if (frame_pos <= PosLonLast) lon_acc = {b, lon_acc[31:8]};
    else if (frame_pos <= PosSeqLast) seq_acc = {b, seq_acc[15:8]};
    else if (frame_pos == PosBatt) batt_byte = b;
    else if (frame_pos == PosCrc) crc_good = (b == run_crc);
    if (frame_pos < FrameBytes) frame_pos++;
    if (last) begin
      rec = '0;
      if (frame_pos < FrameBytes) begin
        rec.status = STATUS_SHORT;
      end else if (!crc_good) begin
        rec.status = STATUS_CRC_ERR;
      end else begin
        rec.status       = STATUS_OK;
        rec.version      = hdr_byte[7:6];
        rec.device_id    = hdr_byte[5:0];
        rec.latitude     = lat_acc;
        rec.longitude    = lon_acc;
        rec.sequence_res = seq_acc;
        rec.battery      = batt_byte;
      end
      expected_records.push_back(rec);
      frame_pos = '0;
      run_crc   = '0;
      crc_good  = 1'b0;
      hdr_byte  = '0;
      lat_acc   = '0;
      lon_acc   = '0;
      seq_acc   = '0;
      batt_byte = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_record();
    result_t want;
    if (expected_records.size() == 0) begin
      $error("unexpected record with status %0d", status);
      errors++;
    end else begin
      want = expected_records.pop_front();
      check_field("status", 32'(want.status), 32'(status));
      check_field("version", 32'(want.version), 32'(version));
      check_field("device_id", 32'(want.device_id), 32'(device_id));
      check_field("latitude", want.latitude, latitude);
      check_field("longitude", want.longitude, longitude);
      check_field("sequence_res", 32'(want.sequence_res), 32'(sequence_res));
      check_field("battery", 32'(want.battery), 32'(battery));
      case (want.status)
        STATUS_OK:      ok_count++;
        STATUS_SHORT:   short_count++;
        default:        crc_err_count++;
      endcase
    end
    records_seen++;
  endtask

  // Driver
  int unsigned idle_left = 0;
  always @(posedge clk) begin : drv
    rx_item_t nxt;
    if (rst) begin
      in_valid      <= 1'b0;
      rx_byte       <= '0;
      end_of_buffer <= 1'b0;
      idle_left     = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(rx_byte, end_of_buffer);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes[0].drain && expected_records.size() != 0) begin
          // hold off until every outstanding record has come back
          in_valid <= 1'b0;
        end else begin
          nxt = pending_bytes.pop_front();
          rx_byte       <= nxt.data;
          end_of_buffer <= nxt.last;
          in_valid      <= 1'b1;
          idle_left     = (pending_bytes.size() != 0) ? pending_bytes[0].gap : 0;
        end
      end
    end
  end

  // Monitor and receiver stall
  int unsigned hold_left      = 0;
  int unsigned next_long_hold = 30;
  int unsigned cycle_cnt      = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      cycle_cnt++;
      if (out_valid && !out_stall) check_record();
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (records_seen >= next_long_hold) begin
        // long hold: let the block back up into its input
        hold_left      = LongHold;
        next_long_hold = next_long_hold + 50;
        out_stall <= 1'b1;
      end else if (((cycle_cnt / 256) % 3) == 0) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 149) == 0) begin
        hold_left = $urandom_range(15, 60);
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Watchdog on transaction progress
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    logic [7:0] body [12];
    bit         calm;
    bit         drain;
    int unsigned kind;

    // Directed: field extremes in a long buffer, a corrupted all-zero
    // record after a full drain, and a one-byte buffer
    body = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
             8'hFF, 8'hFF, 8'hFF};
    add_record(body, 8'h00, 1, 1'b0, 1'b1);
    body = '{default: 8'h00};
    add_record(body, 8'h5A, 0, 1'b1, 1'b0);
    add_short(1, 1'b0, 1'b0);

    while (pending_bytes.size() < ByteTarget) begin
      calm  = ($urandom_range(0, 3) == 0);
      drain = ($urandom_range(0, 39) == 0);
      kind  = $urandom_range(0, 99);
      if (kind < 88) begin
        foreach (body[i]) body[i] = rand_byte();
      end
      if (kind < 68) add_record(body, 8'h00, 0, drain, calm);
      else if (kind < 78) add_record(body, 8'h00, $urandom_range(1, 7), drain, calm);
      else if (kind < 88) add_record(body, 8'($urandom_range(1, 255)),
                                     $urandom_range(0, 3), drain, calm);
      else add_short($urandom_range(1, 12), drain, calm);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_records.size() != 0);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d buffers in %0d bytes, %0d records returned", buffers_built,
             bytes_sent, records_seen);
    $display("records: %0d ok, %0d short, %0d crc mismatch", ok_count, short_count,
             crc_err_count);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
